@@ hw/rtl/kli_pkg.sv @@
`default_nettype none

package kli_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W = 2;
  localparam int FRAC_BITS = 16;
  localparam int MAX_KEYS_DEF = 64;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] key_time;
    logic [DATA_W-1:0] key_x;
    logic [DATA_W-1:0] key_y;
  } key_t;

endpackage

`default_nettype wire

@@ hw/rtl/kli_if.sv @@
`default_nettype none

interface kli_key_if;
  logic                              valid;
  logic                              ready;
  logic [kli_pkg::CMD_W-1:0]         command;
  logic signed [kli_pkg::DATA_W-1:0] key_time;
  logic signed [kli_pkg::DATA_W-1:0] key_x;
  logic signed [kli_pkg::DATA_W-1:0] key_y;

  modport source (output valid, command, key_time, key_x, key_y, input ready);
  modport sink (input valid, command, key_time, key_x, key_y, output ready);
endinterface

interface kli_point_if;
  logic                              valid;
  logic                              ready;
  logic signed [kli_pkg::DATA_W-1:0] point_x;
  logic signed [kli_pkg::DATA_W-1:0] point_y;
  logic                              status;

  modport source (output valid, point_x, point_y, status, input ready);
  modport sink (input valid, point_x, point_y, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/kli_div.sv @@
`default_nettype none

// Restoring divider: quotient = (dividend << FRAC_BITS) / divisor, one bit a cycle.
// The dividend must be below the divisor so the quotient fits FRAC_BITS bits.
module kli_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [kli_pkg::DATA_W-1:0]    dividend,
  input  wire logic [kli_pkg::DATA_W-1:0]    divisor,
  output logic                               done,
  output logic [kli_pkg::FRAC_BITS-1:0]      quot
);

  localparam int CNT_W = $clog2(kli_pkg::FRAC_BITS + 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [kli_pkg::DATA_W-1:0]    rem;
  logic [kli_pkg::DATA_W-1:0]    den;
  logic [kli_pkg::DATA_W:0]      rem_sh;
  logic                          take;

  assign rem_sh = {rem, 1'b0};
  assign take   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(kli_pkg::FRAC_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      den  <= divisor;
      quot <= '0;
    end else if (busy) begin
      if (take) begin
        rem <= rem_sh[kli_pkg::DATA_W-1:0] - den;
      end else begin
        rem <= rem_sh[kli_pkg::DATA_W-1:0];
      end
      quot <= {quot[kli_pkg::FRAC_BITS-2:0], take};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/kli_blend.sv @@
`default_nettype none

// p0 + floor((p1 - p0) * s / 2^FRAC_BITS). Operands in one cycle, result the next.
module kli_blend (
  input  wire logic                              clk,
  input  wire logic signed [kli_pkg::DATA_W-1:0] p0,
  input  wire logic signed [kli_pkg::DATA_W-1:0] p1,
  input  wire logic [kli_pkg::FRAC_BITS-1:0]     s,
  output logic signed [kli_pkg::DATA_W-1:0]      result
);

  localparam int DIFF_W = kli_pkg::DATA_W + 1;
  localparam int PROD_W = DIFF_W + kli_pkg::FRAC_BITS + 1;

  logic signed [DIFF_W-1:0]          diff;
  logic signed [PROD_W-1:0]          prod;
  logic signed [PROD_W-1:0]          prod_q;
  logic signed [kli_pkg::DATA_W-1:0] p0_q;
  logic [PROD_W-kli_pkg::FRAC_BITS-1:0] sum;

  assign diff = {p1[kli_pkg::DATA_W-1], p1} - {p0[kli_pkg::DATA_W-1], p0};
  assign prod = diff * $signed({1'b0, s});

  always_ff @(posedge clk) begin
    prod_q <= prod;
    p0_q   <= p0;
  end

  // Arithmetic shift of the product is the floor division.
  assign sum = {{(PROD_W-kli_pkg::FRAC_BITS-kli_pkg::DATA_W){p0_q[kli_pkg::DATA_W-1]}}, p0_q}
             + prod_q[PROD_W-1:kli_pkg::FRAC_BITS];
  assign result = sum[kli_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/keyframe_linear_interpolator_unit.sv @@
`default_nettype none

// Keyframe table with linear interpolation. Each item is a clear, an append or a
// query and gives exactly one result item. Clear and append go from acceptance
// through the response state back to idle, where the next item can be accepted.
// A query walks the key table one entry a cycle through the single read port of
// the key memory, comparing k entries (at most max(keys, 2)). When it lands before
// the first or past the last key it goes straight to the response state; when it
// lands between two keys the 16-bit blend factor comes from a one-bit-a-cycle
// divider and x and y then share one multiplier. The result sits in an output
// register, so the next item is taken once the sequencer is back to idle even
// while that result waits.
module keyframe_linear_interpolator_unit #(
  parameter int MAX_KEYS = kli_pkg::MAX_KEYS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  kli_key_if.sink          key_in,
  kli_point_if.source      point_out
);

  localparam int IDX_W = $clog2(MAX_KEYS);
  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int DW    = kli_pkg::DATA_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_BLX,
    S_BLY,
    S_BLDONE,
    S_RESP
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            key_count;
  logic [CNT_W-1:0]            cmp_i;
  logic [CNT_W-1:0]            cmp_i_inc;
  logic [CNT_W-1:0]            n_eff;
  logic signed [DW-1:0]        q_time;
  kli_pkg::key_t               prev;
  kli_pkg::key_t               cur;
  kli_pkg::key_t               cur_key;
  logic signed [DW-1:0]        res_x;
  logic signed [DW-1:0]        res_y;
  logic                        res_st;
  logic signed [DW-1:0]        out_x;
  logic signed [DW-1:0]        out_y;
  logic                        out_st;
  logic                        out_valid;
  logic                        out_load;
  logic                        accept;
  logic                        full;
  logic                        wr_en;
  logic                        hit;

  kli_pkg::key_t               mem [MAX_KEYS];
  kli_pkg::key_t               rd_data;
  logic [IDX_W-1:0]            rd_idx;

  logic                        div_start;
  logic [DW-1:0]               div_dividend;
  logic [DW-1:0]               div_divisor;
  logic                        div_done;
  logic [kli_pkg::FRAC_BITS-1:0] div_quot;

  logic signed [DW-1:0]        bl_p0;
  logic signed [DW-1:0]        bl_p1;
  logic signed [DW-1:0]        bl_result;

  assign key_in.ready      = (state == S_IDLE);
  assign accept            = key_in.valid && key_in.ready;
  assign full              = (key_count == CNT_W'(MAX_KEYS));
  assign wr_en             = accept && (key_in.command == kli_pkg::CMD_APPEND) && !full;
  assign point_out.valid   = out_valid;
  assign point_out.point_x = out_x;
  assign point_out.point_y = out_y;
  assign point_out.status  = out_st;
  assign out_load          = (state == S_RESP) && (!out_valid || point_out.ready);

  assign n_eff     = (key_count < CNT_W'(2)) ? CNT_W'(2) : key_count;
  assign cmp_i_inc = cmp_i + CNT_W'(1);
  // Entries past the loaded count stand in as zero keys.
  assign cur_key   = (cmp_i < key_count) ? rd_data : '0;
  assign hit       = q_time < $signed(cur_key.key_time);

  always_comb begin
    rd_idx = '0;
    if (state == S_SCAN) begin
      rd_idx = cmp_i_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[key_count[IDX_W-1:0]] <= '{key_time: key_in.key_time,
                                      key_x:    key_in.key_x,
                                      key_y:    key_in.key_y};
    end
    rd_data <= mem[rd_idx];
  end

  assign div_start    = (state == S_SCAN) && hit && (cmp_i != '0);
  assign div_dividend = q_time - prev.key_time;
  assign div_divisor  = cur_key.key_time - prev.key_time;

  kli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign bl_p0 = (state == S_BLX) ? prev.key_x : prev.key_y;
  assign bl_p1 = (state == S_BLX) ? cur.key_x : cur.key_y;

  kli_blend u_blend (
    .clk    (clk),
    .p0     (bl_p0),
    .p1     (bl_p1),
    .s      (div_quot),
    .result (bl_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && point_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_x  <= '0;
            res_y  <= '0;
            res_st <= ((key_in.command == kli_pkg::CMD_APPEND) && full) ?
                      kli_pkg::STATUS_FULL : kli_pkg::STATUS_OK;
            q_time <= key_in.key_time;
            cmp_i  <= '0;
            state  <= (key_in.command == kli_pkg::CMD_QUERY) ? S_SCAN : S_RESP;
            case (kli_pkg::cmd_t'(key_in.command))
              kli_pkg::CMD_CLEAR: begin
                key_count <= '0;
              end
              kli_pkg::CMD_APPEND: begin
                if (!full) begin
                  key_count <= key_count + CNT_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (cmp_i == '0) begin
              // Before the first key: hold its point.
              res_x <= cur_key.key_x;
              res_y <= cur_key.key_y;
              state <= S_RESP;
            end else begin
              cur   <= cur_key;
              state <= S_DIV;
            end
          end else if (cmp_i_inc == n_eff) begin
            // Past the last key.
            res_x <= cur_key.key_x;
            res_y <= cur_key.key_y;
            state <= S_RESP;
          end else begin
            prev  <= cur_key;
            cmp_i <= cmp_i_inc;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_BLX;
          end
        end
        S_BLX: begin
          state <= S_BLY;
        end
        S_BLY: begin
          res_x <= bl_result;
          state <= S_BLDONE;
        end
        S_BLDONE: begin
          res_y <= bl_result;
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_load) begin
            out_x  <= res_x;
            out_y  <= res_y;
            out_st <= res_st;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= CNT_W'(MAX_KEYS))
    else $error("key count above table depth");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> key_count == $past(key_count) + CNT_W'(1))
    else $error("append did not advance key count");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

  a_drop_zero_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_st == kli_pkg::STATUS_FULL) |-> out_x == '0 && out_y == '0)
    else $error("dropped append carries a nonzero point");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> cmp_i < n_eff)
    else $error("scan index past effective table");

endmodule

`default_nettype wire
